>>> rtl/kv_record_stream_parser_assert.svh
// Assertion macros shared by the parser RTL.
// Each macro expects clk and rst_n in scope.
`ifndef KV_RECORD_STREAM_PARSER_ASSERT_SVH
`define KV_RECORD_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset
`define KVRSP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("kvrsp assertion failed");

// Check that a trigger implies a condition in the same cycle
`define KVRSP_ASSERT_IMPLY(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("kvrsp assertion failed");

// Check that a trigger implies a condition in the next cycle
`define KVRSP_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("kvrsp assertion failed");

`else

`define KVRSP_ASSERT_ALWAYS(label, cond)
`define KVRSP_ASSERT_IMPLY(label, trig, cond)
`define KVRSP_ASSERT_NEXT(label, trig, cond)

`endif

`endif

>>> rtl/kvrsp_pkg.sv
package kvrsp_pkg;

    // Record header layout
    localparam int HEADER_BYTES = 21;
    localparam int HDR_HELD     = HEADER_BYTES - 1;
    localparam logic [31:0] MAGIC_WORD = 32'h544b5653;

    // Field widths
    localparam int KEY_LEN_W   = 27;
    localparam int VALUE_LEN_W = 29;
    localparam int COUNT_W     = 29;
    localparam int TDATA_W     = 264;
    localparam int TUSER_W     = 3;

    // Limit register reset values
    localparam logic [KEY_LEN_W-1:0]   MAX_KEY_RESET   = KEY_LEN_W'(1 << 26);
    localparam logic [VALUE_LEN_W-1:0] MAX_VALUE_RESET = VALUE_LEN_W'(1 << 28);

    // Configuration register indexes
    localparam logic REG_MAX_KEY_LEN   = 1'b0;
    localparam logic REG_MAX_VALUE_LEN = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_VALUE  = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CORRUPT   = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_KEY    = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_ERROR  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        kind_t                  out_kind;
        status_t                status;
        logic [63:0]            sequence_res;
        logic                   tombstone;
        logic [KEY_LEN_W-1:0]   key_len;
        logic [VALUE_LEN_W-1:0] value_len;
        logic [63:0]            record_offset;
        logic [63:0]            max_sequence;
        logic [7:0]             payload_byte;
        logic                   last_of_field;
        logic                   record_done;
    } result_t;

    typedef struct packed {
        logic [KEY_LEN_W-1:0]   max_key_len;
        logic [VALUE_LEN_W-1:0] max_value_len;
    } limits_t;

endpackage

>>> rtl/kv_record_stream_parser.sv
// Channel   Direction  Payload
// s_*       in         tdata: data_byte; tuser: stream_end
// m_*       out        tdata: header/byte fields; tuser: out_kind, record_done;
//                      tlast: last_of_field
// cfg_*     in         cfg_index selects the limit, cfg_data is written to it
//
// One item per cycle sustained while m_tready is high; each item passes through the
// input register and then the result register.
// The rate is set by the single decode step between the two registers.
// rst_n clears the parser to the header phase and the limits to their defaults.
// A stall on m_tready holds the result; s_tready drops only while both stages hold.
// Configuration writes are always taken; cfg_ready is tied high.
`include "kv_record_stream_parser_assert.svh"

module kv_record_stream_parser
    import kvrsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte
    input  logic                   s_tuser,   // stream_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // status, sequence_res, tombstone, key_len,
                                              // value_len, record_offset, max_sequence,
                                              // payload_byte
    output logic [TUSER_W-1:0]     m_tuser,   // out_kind, record_done
    output logic                   m_tlast,   // last_of_field
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [VALUE_LEN_W-1:0] cfg_data
);

    logic     item_valid;
    in_item_t item;
    logic     out_free;
    logic     step;
    logic     res_valid;
    result_t  res;
    limits_t  limits_reg;
    limits_t  limits_next;

    assign step      = item_valid && out_free;
    assign cfg_ready = 1'b1;

    // Decode limit register writes
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_KEY_LEN:   limits_next.max_key_len   = cfg_data[KEY_LEN_W-1:0];
                REG_MAX_VALUE_LEN: limits_next.max_value_len = cfg_data;
                default:           limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_key_len   <= MAX_KEY_RESET;
            limits_reg.max_value_len <= MAX_VALUE_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    kvrsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    kvrsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .limits    (limits_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    kvrsp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Input back-pressure only comes from a stalled, full result register
    `KVRSP_ASSERT_IMPLY(a_stall_source, !s_tready, m_tvalid && !m_tready)
    // An error is final: nothing follows it
    `KVRSP_ASSERT_NEXT(a_error_final, m_tvalid && m_tready && m_tuser[1:0] == KIND_ERROR,
        !m_tvalid)
    // Field ends only mark key or value bytes
    `KVRSP_ASSERT_IMPLY(a_last_on_payload, m_tvalid && m_tlast,
        m_tuser[1:0] == KIND_KEY || m_tuser[1:0] == KIND_VALUE)
    // Non-error results carry an ok status
    `KVRSP_ASSERT_IMPLY(a_status_ok, m_tvalid && m_tuser[1:0] != KIND_ERROR,
        m_tdata[1:0] == ST_OK)

endmodule

>>> rtl/kvrsp_in_reg.sv
module kvrsp_in_reg
    import kvrsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tuser,    // [0] stream_end
    input  logic       advance,
    output logic       item_valid,
    output in_item_t   item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new item whenever the register is empty or drains this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte  <= s_tdata;
            item_reg.stream_end <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/kvrsp_parse.sv
module kvrsp_parse
    import kvrsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_item_t item,
    input  limits_t  limits,
    output logic     res_valid,
    output result_t  res
);

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [KEY_LEN_W-1:0] key_len_reg, key_len_next;
    logic [VALUE_LEN_W-1:0] value_len_reg, value_len_next;
    logic [63:0]          offset_reg, offset_next;
    logic [63:0]          start_reg, start_next;
    logic [63:0]          max_seq_reg, max_seq_next;
    logic [7:0]           hdr_reg [HDR_HELD];

    logic [COUNT_W-1:0]   count_inc;
    logic [31:0]          magic;
    logic [63:0]          seq;
    logic [31:0]          ks;
    logic [31:0]          vs;
    logic [63:0]          seq_max;
    logic                 hdr_last;

    // Header fields; the final byte comes straight from the input
    assign magic = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign seq   = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8],
                    hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    assign ks    = {hdr_reg[16], hdr_reg[15], hdr_reg[14], hdr_reg[13]};
    assign vs    = {item.data_byte, hdr_reg[19], hdr_reg[18], hdr_reg[17]};

    assign seq_max   = (seq > max_seq_reg) ? seq : max_seq_reg;
    assign count_inc = count_reg + COUNT_W'(1);
    assign hdr_last  = (count_reg == COUNT_W'(HDR_HELD));

    // Per-item decode and next state
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        key_len_next   = key_len_reg;
        value_len_next = value_len_reg;
        offset_next    = offset_reg;
        start_next     = start_reg;
        max_seq_next   = max_seq_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (step)
        begin
            unique case (phase_reg) inside
                PH_HEADER:
                begin
                    if (item.stream_end)
                    begin
                        if (count_reg != '0)
                        begin
                            res_valid         = 1'b1;
                            res.out_kind      = KIND_ERROR;
                            res.status        = ST_CORRUPT;
                            res.record_offset = start_reg;
                            phase_next        = PH_ERROR;
                        end
                    end
                    else
                    begin
                        offset_next = offset_reg + 64'd1;
                        if (count_reg == '0)
                        begin
                            start_next = offset_reg;
                        end
                        count_next = count_inc;
                        if (hdr_last)
                        begin
                            res_valid         = 1'b1;
                            res.record_offset = start_reg;
                            count_next        = '0;
                            if (magic != MAGIC_WORD)
                            begin
                                res.out_kind = KIND_ERROR;
                                res.status   = ST_CORRUPT;
                                phase_next   = PH_ERROR;
                            end
                            else if (ks > 32'(limits.max_key_len)
                                     || vs > 32'(limits.max_value_len))
                            begin
                                res.out_kind = KIND_ERROR;
                                res.status   = ST_BAD_SIZE;
                                phase_next   = PH_ERROR;
                            end
                            else
                            begin
                                max_seq_next     = seq_max;
                                key_len_next     = ks[KEY_LEN_W-1:0];
                                value_len_next   = vs[VALUE_LEN_W-1:0];
                                res.out_kind     = KIND_HEADER;
                                res.status       = ST_OK;
                                res.sequence_res = seq;
                                res.tombstone    = (hdr_reg[12] != 8'd0);
                                res.key_len      = ks[KEY_LEN_W-1:0];
                                res.value_len    = vs[VALUE_LEN_W-1:0];
                                res.max_sequence = seq_max;
                                res.record_done  = (ks == '0) && (vs == '0);
                                if (ks != '0)
                                begin
                                    phase_next = PH_KEY;
                                end
                                else if (vs != '0)
                                begin
                                    phase_next = PH_VALUE;
                                end
                            end
                        end
                    end
                end
                PH_KEY, PH_VALUE:
                begin
                    if (item.stream_end)
                    begin
                        res_valid         = 1'b1;
                        res.out_kind      = KIND_ERROR;
                        res.status        = ST_TRUNCATED;
                        res.record_offset = start_reg;
                        phase_next        = PH_ERROR;
                    end
                    else
                    begin
                        offset_next      = offset_reg + 64'd1;
                        res_valid        = 1'b1;
                        res.payload_byte = item.data_byte;
                        count_next       = count_inc;
                        if (phase_reg == PH_KEY)
                        begin
                            res.out_kind = KIND_KEY;
                            if (count_inc == COUNT_W'(key_len_reg))
                            begin
                                res.last_of_field = 1'b1;
                                res.record_done   = (value_len_reg == '0);
                                count_next        = '0;
                                phase_next = (value_len_reg != '0) ? PH_VALUE : PH_HEADER;
                            end
                        end
                        else
                        begin
                            res.out_kind = KIND_VALUE;
                            if (count_inc == value_len_reg)
                            begin
                                res.last_of_field = 1'b1;
                                res.record_done   = 1'b1;
                                count_next        = '0;
                                phase_next        = PH_HEADER;
                            end
                        end
                    end
                end
                PH_ERROR:
                begin
                    // drop everything until reset
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            count_reg     <= '0;
            key_len_reg   <= '0;
            value_len_reg <= '0;
            offset_reg    <= '0;
            start_reg     <= '0;
            max_seq_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            key_len_reg   <= key_len_next;
            value_len_reg <= value_len_next;
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            max_seq_reg   <= max_seq_next;
        end
    end

    // Shift header bytes in; the oldest ends up at entry zero
    always_ff @(posedge clk)
    begin
        if (step && phase_reg == PH_HEADER && !item.stream_end)
        begin
            for (int i = 0; i < HDR_HELD - 1; i++)
            begin
                hdr_reg[i] <= hdr_reg[i+1];
            end
            hdr_reg[HDR_HELD-1] <= item.data_byte;
        end
    end

endmodule

>>> rtl/kvrsp_out_reg.sv
module kvrsp_out_reg
    import kvrsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               res_valid,
    input  result_t            res,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // status, sequence_res, tombstone, key_len,
                                         // value_len, record_offset, max_sequence,
                                         // payload_byte, zero pad
    output logic [TUSER_W-1:0] m_tuser,  // out_kind, record_done
    output logic               m_tlast   // last_of_field
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or the held item leaves this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    // Pack the result fields, lowest first
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, res_reg.payload_byte, res_reg.max_sequence,
                       res_reg.record_offset, res_reg.value_len, res_reg.key_len,
                       res_reg.tombstone, res_reg.sequence_res, res_reg.status};
    assign m_tuser  = {res_reg.record_done, res_reg.out_kind};
    assign m_tlast  = res_reg.last_of_field;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import kvrsp_pkg::*;

    localparam int RAND_ITEMS = 1450;
    localparam int HOLD_CYCLES = 400;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;   // data_byte
    logic                     s_tuser;   // stream_end
    logic                     m_tvalid;
    logic                     m_tready;
    logic [TDATA_W-1:0]       m_tdata;   // status, sequence_res, tombstone, key_len,
                                         // value_len, record_offset, max_sequence,
                                         // payload_byte
    logic [TUSER_W-1:0]       m_tuser;   // out_kind, record_done
    logic                     m_tlast;   // last_of_field
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [VALUE_LEN_W-1:0]   cfg_data;

    kv_record_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Parser state as the stream should leave it
    phase_t                 st_phase = PH_HEADER;
    logic [7:0]             hdr_buf [HEADER_BYTES];
    logic [31:0]            byte_cnt = '0;
    logic [31:0]            held_klen = '0;
    logic [31:0]            held_vlen = '0;
    logic [63:0]            byte_offset = '0;
    logic [63:0]            rec_start = '0;
    logic [63:0]            seq_high = '0;
    logic [KEY_LEN_W-1:0]   lim_key = MAX_KEY_RESET;
    logic [VALUE_LEN_W-1:0] lim_val = MAX_VALUE_RESET;
    result_t                last_hdr = '0;
    result_t                last_err = '0;

    // Results still owed by the parser, oldest first
    result_t parsed_q [$];

    int mismatch_count = 0;
    int accepted_items = 0;
    int src_idle_pct = 28;
    int snk_stall_pct = 54;
    int hold_at = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Directed records: limits to load first, header fields, and the running
    // maximum sequence to find in the header item where it is obvious
    typedef struct {
        bit                     set_lim;
        logic [KEY_LEN_W-1:0]   lk;
        logic [VALUE_LEN_W-1:0] lv;
        logic [63:0]            seq;
        logic [7:0]             tomb;
        logic [31:0]            klen;
        logic [31:0]            vlen;
        bit                     end_after;
        bit                     chk;
        logic [63:0]            want_max;
    } rec_row_t;

    rec_row_t dir_rows [0:10] = '{
        '{0, 0, 0, 64'd0, 8'h00, 0, 0, 0, 1, 64'd0},
        '{0, 0, 0, 64'd5, 8'hFF, 1, 1, 1, 1, 64'd5},
        '{0, 0, 0, 64'd3, 8'h01, 3, 0, 0, 1, 64'd5},
        '{0, 0, 0, 64'h0123_4567_89AB_CDEF, 8'h80, 0, 4, 0, 0, 64'd0},
        '{0, 0, 0, 64'd9, 8'h00, 2, 3, 1, 0, 64'd0},
        '{1, 0, 0, 64'd10, 8'h00, 0, 0, 0, 0, 64'd0},
        '{0, 0, 0, 64'd11, 8'h7F, 0, 0, 1, 0, 64'd0},
        '{1, 5, 7, 64'd12, 8'h00, 5, 7, 0, 0, 64'd0},
        '{0, 0, 0, 64'd13, 8'h02, 4, 6, 0, 0, 64'd0},
        '{1, 27'h7FF_FFFF, 29'h1FFF_FFFF, 64'h0123_4567_89AB_CDF0, 8'h00, 10, 20, 0, 1,
          64'h0123_4567_89AB_CDF0},
        '{0, 0, 0, 64'h0123_4567_89AB_CDF1, 8'h00, 1, 0, 1, 0, 64'd0}
    };

    // Advance the parser state by one item; return 1 when it owes a result
    function automatic bit parse_step(input logic [7:0] b, input logic fin,
                                      output result_t r);
        logic [31:0] ks;
        logic [31:0] vs;
        logic [31:0] magic;
        logic [63:0] seq;
        status_t     err;
        r = '0;
        err = ST_OK;
        if (st_phase == PH_ERROR)
            return 1'b0;
        if (fin) begin
            // end of stream at a record boundary is clean
            if (st_phase == PH_HEADER && byte_cnt == 0)
                return 1'b0;
            err = (st_phase == PH_HEADER) ? ST_CORRUPT : ST_TRUNCATED;
        end
        else if (st_phase == PH_HEADER) begin
            if (byte_cnt == 0)
                rec_start = byte_offset;
            byte_offset++;
            hdr_buf[byte_cnt] = b;
            byte_cnt++;
            if (byte_cnt < HEADER_BYTES)
                return 1'b0;
            magic = {hdr_buf[3], hdr_buf[2], hdr_buf[1], hdr_buf[0]};
            seq = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8],
                   hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
            ks = {hdr_buf[16], hdr_buf[15], hdr_buf[14], hdr_buf[13]};
            vs = {hdr_buf[20], hdr_buf[19], hdr_buf[18], hdr_buf[17]};
            if (magic != MAGIC_WORD)
                err = ST_CORRUPT;
            else if (ks > 32'(lim_key) || vs > 32'(lim_val))
                err = ST_BAD_SIZE;
            else begin
                if (seq > seq_high)
                    seq_high = seq;
                held_klen = ks;
                held_vlen = vs;
                byte_cnt = '0;
                r.out_kind = KIND_HEADER;
                r.status = ST_OK;
                r.sequence_res = seq;
                r.tombstone = (hdr_buf[12] != 8'd0);
                r.key_len = ks[KEY_LEN_W-1:0];
                r.value_len = vs[VALUE_LEN_W-1:0];
                r.record_offset = rec_start;
                r.max_sequence = seq_high;
                r.record_done = (ks == 0 && vs == 0);
                st_phase = (ks != 0) ? PH_KEY : (vs != 0) ? PH_VALUE : PH_HEADER;
                last_hdr = r;
                return 1'b1;
            end
        end
        else begin
            // pass key and value bytes through
            byte_offset++;
            byte_cnt++;
            r.payload_byte = b;
            if (st_phase == PH_KEY) begin
                r.out_kind = KIND_KEY;
                if (byte_cnt >= held_klen) begin
                    r.last_of_field = 1'b1;
                    r.record_done = (held_vlen == 0);
                    byte_cnt = '0;
                    st_phase = (held_vlen != 0) ? PH_VALUE : PH_HEADER;
                end
            end
            else begin
                r.out_kind = KIND_VALUE;
                if (byte_cnt >= held_vlen) begin
                    r.last_of_field = 1'b1;
                    r.record_done = 1'b1;
                    byte_cnt = '0;
                    st_phase = PH_HEADER;
                end
            end
            return 1'b1;
        end
        // errors stick until reset
        r.out_kind = KIND_ERROR;
        r.status = err;
        r.record_offset = rec_start;
        st_phase = PH_ERROR;
        last_err = r;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one item, then log what it should produce once it is taken
    task automatic push_byte(input logic [7:0] b, input logic fin);
        result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= fin;
        do @(posedge clk); while (!s_tready);
        accepted_items++;
        if (parse_step(b, fin, r))
            parsed_q.insert(parsed_q.size(), r);
        @(negedge clk);
    endtask

    // Send a record; cut >= 0 stops after that many bytes
    task automatic send_record(input logic [31:0] magic, input logic [63:0] seq,
                               input logic [7:0] tomb, input logic [31:0] klen,
                               input logic [31:0] vlen, input int cut);
        logic [167:0] hdr;
        int total;
        hdr = {vlen, klen, tomb, seq, magic};
        total = (cut >= 0) ? cut : HEADER_BYTES + int'(klen) + int'(vlen);
        for (int i = 0; i < total; i++) begin
            if (i < HEADER_BYTES)
                push_byte(hdr[8*i +: 8], 1'b0);
            else
                push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Hold the input until every owed result is out and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (parsed_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Load both length limits back to back
    task automatic write_limits(input logic [KEY_LEN_W-1:0] lk,
                                input logic [VALUE_LEN_W-1:0] lv);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_KEY_LEN;
        cfg_data <= VALUE_LEN_W'(lk);
        do @(posedge clk); while (!cfg_ready);
        lim_key = lk;
        @(negedge clk);
        cfg_index <= REG_MAX_VALUE_LEN;
        cfg_data <= lv;
        do @(posedge clk); while (!cfg_ready);
        lim_val = lv;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!hold_done && hold_at > 0 && accepted_items >= hold_at) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Compare each result item with the oldest owed one
    always @(posedge clk)
    begin : watch_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[1:0]);
            got.sequence_res = m_tdata[65:2];
            got.tombstone = m_tdata[66];
            got.key_len = m_tdata[93:67];
            got.value_len = m_tdata[122:94];
            got.record_offset = m_tdata[186:123];
            got.max_sequence = m_tdata[250:187];
            got.payload_byte = m_tdata[258:251];
            got.out_kind = kind_t'(m_tuser[1:0]);
            got.record_done = m_tuser[2];
            got.last_of_field = m_tlast;
            if (parsed_q.size() == 0) begin
                $display("%0t: result item expected none, got kind %0d", $time,
                         got.out_kind);
                mismatch_count++;
            end
            else begin
                want = parsed_q.pop_front();
                check_field("out_kind", want.out_kind, got.out_kind);
                check_field("status", want.status, got.status);
                check_field("sequence_res", want.sequence_res, got.sequence_res);
                check_field("tombstone", want.tombstone, got.tombstone);
                check_field("key_len", want.key_len, got.key_len);
                check_field("value_len", want.value_len, got.value_len);
                check_field("record_offset", want.record_offset, got.record_offset);
                check_field("max_sequence", want.max_sequence, got.max_sequence);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("last_of_field", want.last_of_field, got.last_of_field);
                check_field("record_done", want.record_done, got.record_done);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int rand_base;
        int seg;
        int cur_seg;
        int kcap;
        int vcap;
        int klen;
        int vlen;
        logic [63:0] seq;
        logic [7:0] tomb;
        status_t err_pick;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_KEY_LEN;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed records, limits and clean ends
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_lim) begin
                drain_results();
                write_limits(dir_rows[i].lk, dir_rows[i].lv);
            end
            send_record(MAGIC_WORD, dir_rows[i].seq, dir_rows[i].tomb,
                        dir_rows[i].klen, dir_rows[i].vlen, -1);
            if (dir_rows[i].chk && last_hdr.max_sequence !== dir_rows[i].want_max) begin
                $display("%0t: running max sequence expected %h, got %h", $time,
                         dir_rows[i].want_max, last_hdr.max_sequence);
                mismatch_count++;
            end
            if (dir_rows[i].end_after)
                push_byte(8'($urandom_range(0, 255)), 1'b1);
        end

        // Random well-formed records in three idling segments
        rand_base = accepted_items;
        hold_at = rand_base + 300;
        cur_seg = -1;
        while (accepted_items < rand_base + RAND_ITEMS) begin
            seg = ((accepted_items - rand_base) * 3) / RAND_ITEMS;
            if (seg > 2)
                seg = 2;
            if (seg != cur_seg) begin
                cur_seg = seg;
                src_idle_pct = (seg == 0) ? 28 : (seg == 1) ? 54 : 0;
                snk_stall_pct = (seg == 0) ? 54 : (seg == 1) ? 28 : 0;
                drain_results();
                if (seg == 1)
                    write_limits(27'h7FF_FFFF, VALUE_LEN_W'($urandom_range(0, 24)));
                else
                    write_limits(KEY_LEN_W'($urandom_range(0, 24)),
                                 VALUE_LEN_W'($urandom_range(0, 24)));
            end
            if ($urandom_range(0, 11) == 0)
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            kcap = (lim_key > 16) ? 16 : int'(lim_key);
            vcap = (lim_val > 16) ? 16 : int'(lim_val);
            klen = $urandom_range(0, kcap);
            vlen = $urandom_range(0, vcap);
            if ($urandom_range(0, 3) == 0)
                seq = seq_high - 64'($urandom_range(0, 1000));
            else
                seq = seq_high + 64'($urandom_range(1, 1 << 20));
            tomb = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
            send_record(MAGIC_WORD, seq, tomb, klen, vlen, -1);
        end
        send_record(MAGIC_WORD, '1, 8'h00, 0, 0, -1);

        // One error closes the stream for good
        drain_results();
        write_limits(KEY_LEN_W'(8), VALUE_LEN_W'(8));
        err_pick = status_t'($urandom_range(1, 3));
        seq = {$urandom, $urandom};
        case (err_pick)
            ST_CORRUPT: begin
                if ($urandom_range(0, 1)) begin
                    send_record(MAGIC_WORD ^ (32'h1 << $urandom_range(0, 31)), seq,
                                8'h00, 2, 2, HEADER_BYTES);
                end
                else begin
                    send_record(MAGIC_WORD, seq, 8'h00, 2, 2,
                                $urandom_range(1, HEADER_BYTES - 1));
                    push_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            ST_BAD_SIZE: begin
                case ($urandom_range(0, 2))
                    0: send_record(MAGIC_WORD, seq, 8'h00, 9, 0, HEADER_BYTES);
                    1: send_record(MAGIC_WORD, seq, 8'h00, 0, 9, HEADER_BYTES);
                    default: send_record(MAGIC_WORD, seq, 8'h00, 32'hF000_0000, 0,
                                         HEADER_BYTES);
                endcase
            end
            default: begin
                klen = $urandom_range(1, 8);
                vlen = $urandom_range(1, 8);
                send_record(MAGIC_WORD, seq, 8'h00, klen, vlen,
                            HEADER_BYTES + $urandom_range(0, klen + vlen - 1));
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        if (last_err.out_kind !== KIND_ERROR || last_err.status !== err_pick) begin
            $display("%0t: error status expected %0d, got %0d", $time, err_pick,
                     last_err.status);
            mismatch_count++;
        end

        // Anything after the error must be swallowed
        repeat (20) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain_results();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
